// ----- hw/rtl/tdne_pkg.sv -----
// shared constants and types for the token dictionary name expander
package tdne_pkg;

   localparam int TOKEN_STORE_BYTES = 4096;
   localparam int MAX_TOKEN_RUN     = 32;
   localparam int RUN_CAP           = (MAX_TOKEN_RUN < 31) ? MAX_TOKEN_RUN : 31;
   localparam int TS_AW             = $clog2(TOKEN_STORE_BYTES);
   localparam int RUN_W             = $clog2(RUN_CAP + 1);
   localparam int IDX_DEPTH         = 256;
   localparam int IDX_AW            = $clog2(IDX_DEPTH);

   localparam logic [1:0] MODE_TOKEN_BYTE = 2'd0;
   localparam logic [1:0] MODE_INDEX      = 2'd1;
   localparam logic [1:0] MODE_NAME       = 2'd2;

   // load writes into the two stores
   typedef struct packed {
      logic              byte_we;
      logic [TS_AW-1:0]  byte_waddr;
      logic [7:0]        byte_wdata;
      logic              start_we;
      logic [IDX_AW-1:0] start_waddr;
      logic [TS_AW-1:0]  start_wdata;
   } store_wr_type;

   // read addresses driven by the sequencer
   typedef struct packed {
      logic [TS_AW-1:0]  byte_raddr;
      logic [IDX_AW-1:0] start_raddr;
   } store_rd_type;

endpackage

// ----- hw/rtl/token_dictionary_name_expander.sv -----
// Token dictionary name expander, top level.
// Input words (req_) carry a mode: mode 0 writes a token byte at req_where,
// mode 1 writes a token start offset into index slot req_where[7:0], mode 2
// is a byte of a length-prefixed compressed name, mode 3 is ignored.
// A name byte opens a name (length) or selects a token (code). The token is
// walked from its start offset one byte per cycle while the result register
// is not stalled, up to its zero byte or 31 bytes; each character leaves as
// one word on the rsp_ channel. The first byte of every name is dropped, and
// the last word of a name is an end marker. Loads and nonzero length bytes
// leave req_ready high; a zero length byte goes through the end marker state.
// A code byte keeps req_ready low through the index read, the walk of the
// byte store through its single read port, the flush of the held last
// character or cut flag and, when it ends the name, the end marker.
// One character is held back until the next byte shows whether it is last.
// When the receiver stalls, the result register holds its word and the walk
// pauses; no word is lost. Reset clears the name state and the result valid
// flag; the stores are not cleared and must be loaded before use.
module token_dictionary_name_expander
   import tdne_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [11:0] req_where,
   input  logic [11:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_symbol_char,
   output logic        rsp_char_valid,
   output logic        rsp_run_last,
   output logic        rsp_symbol_end,
   output logic        rsp_token_cut
);

   logic             req_accept;
   logic             name_accept;
   logic             idle;
   logic [TS_AW-1:0] byte_addr_full;
   logic [TS_AW-1:0] start_val_full;
   logic [7:0]       byte_rdata;
   logic [TS_AW-1:0] start_rdata;
   store_wr_type     wr;
   store_rd_type     rd;

   assign req_ready  = idle;
   assign req_accept = req_valid && req_ready;

   assign byte_addr_full = TS_AW'(32'(req_where) % TOKEN_STORE_BYTES);
   assign start_val_full = TS_AW'(32'(req_value) % TOKEN_STORE_BYTES);

   always_comb begin
      wr.byte_we     = 1'b0;
      wr.start_we    = 1'b0;
      name_accept    = 1'b0;
      wr.byte_waddr  = byte_addr_full;
      wr.byte_wdata  = req_value[7:0];
      wr.start_waddr = req_where[IDX_AW-1:0];
      wr.start_wdata = start_val_full;
      if (req_accept) begin
         unique case (req_mode)
            MODE_TOKEN_BYTE: wr.byte_we  = 1'b1;
            MODE_INDEX:      wr.start_we = 1'b1;
            MODE_NAME:       name_accept = 1'b1;
            default:         name_accept = 1'b0;
         endcase
      end
   end

   tdne_store u_store (
      .clock       (clock),
      .wr          (wr),
      .rd          (rd),
      .byte_rdata  (byte_rdata),
      .start_rdata (start_rdata)
   );

   tdne_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .name_accept     (name_accept),
      .name_byte       (req_value[7:0]),
      .byte_rdata      (byte_rdata),
      .start_rdata     (start_rdata),
      .rd              (rd),
      .idle            (idle),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_symbol_char (rsp_symbol_char),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_symbol_end  (rsp_symbol_end),
      .rsp_token_cut   (rsp_token_cut)
   );

endmodule

// ----- hw/rtl/tdne_store.sv -----
// token byte store and token start index, registered reads
module tdne_store
   import tdne_pkg::*;
(
   input  logic              clock,
   input  store_wr_type      wr,
   input  store_rd_type      rd,
   output logic [7:0]        byte_rdata,
   output logic [TS_AW-1:0]  start_rdata
);

   logic [7:0]       byte_mem [TOKEN_STORE_BYTES];
   logic [TS_AW-1:0] start_mem [IDX_DEPTH];
   logic [7:0]       byte_rdata_ff;
   logic [TS_AW-1:0] start_rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.byte_we) begin
         byte_mem[wr.byte_waddr] <= wr.byte_wdata;
      end
      byte_rdata_ff <= byte_mem[rd.byte_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr.start_we) begin
         start_mem[wr.start_waddr] <= wr.start_wdata;
      end
      start_rdata_ff <= start_mem[rd.start_raddr];
   end

   assign byte_rdata  = byte_rdata_ff;
   assign start_rdata = start_rdata_ff;

endmodule

// ----- hw/rtl/tdne_seq.sv -----
// sequencer walks a token a byte per cycle unless stalled; drives result register
module tdne_seq
   import tdne_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             name_accept,
   input  logic [7:0]       name_byte,
   input  logic [7:0]       byte_rdata,
   input  logic [TS_AW-1:0] start_rdata,
   output store_rd_type     rd,
   output logic             idle,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [7:0]       rsp_symbol_char,
   output logic             rsp_char_valid,
   output logic             rsp_run_last,
   output logic             rsp_symbol_end,
   output logic             rsp_token_cut
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_WALK,
      S_FLUSH,
      S_MARK
   } state_type;

   state_type        state_ff, state_in;
   logic [7:0]       codes_left_ff, codes_left_in;
   logic             first_dropped_ff, first_dropped_in;
   logic             ends_ff, ends_in;
   logic             cut_ff, cut_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [7:0]       hold_char_ff, hold_char_in;
   logic [TS_AW-1:0] pos_ff, pos_in;
   logic [RUN_W-1:0] run_ff, run_in;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_cv_ff, out_cv_in;
   logic             out_last_ff, out_last_in;
   logic             out_end_ff, out_end_in;
   logic             out_cut_ff, out_cut_in;

   logic             out_free;
   logic             push;
   logic [7:0]       push_char;
   logic             push_cv;
   logic             push_last;
   logic             push_end;
   logic             push_cut;
   logic             run_full;

   assign out_free = !out_valid_ff || rsp_ready;
   assign run_full = (run_ff == RUN_W'(RUN_CAP));

   always_comb begin
      state_in         = state_ff;
      codes_left_in    = codes_left_ff;
      first_dropped_in = first_dropped_ff;
      ends_in          = ends_ff;
      cut_in           = cut_ff;
      hold_valid_in    = hold_valid_ff;
      hold_char_in     = hold_char_ff;
      pos_in           = pos_ff;
      run_in           = run_ff;
      push             = 1'b0;
      push_char        = 8'd0;
      push_cv          = 1'b0;
      push_last        = 1'b0;
      push_end         = 1'b0;
      push_cut         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (name_accept) begin
               if (codes_left_ff == 8'd0) begin
                  // length byte opens a new name
                  codes_left_in    = name_byte;
                  first_dropped_in = 1'b0;
                  if (name_byte == 8'd0) begin
                     cut_in   = 1'b0;
                     state_in = S_MARK;
                  end
               end else begin
                  codes_left_in = codes_left_ff - 8'd1;
                  ends_in       = (codes_left_ff == 8'd1);
                  hold_valid_in = 1'b0;
                  state_in      = S_LOOKUP;
               end
            end
         end
         S_LOOKUP: begin
            pos_in   = start_rdata;
            run_in   = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (byte_rdata == 8'd0 || run_full) begin
               cut_in   = run_full && (byte_rdata != 8'd0);
               state_in = S_FLUSH;
            end else if (!first_dropped_ff) begin
               first_dropped_in = 1'b1;
               pos_in           = pos_ff + TS_AW'(1);
               run_in           = run_ff + RUN_W'(1);
            end else if (!hold_valid_ff || out_free) begin
               // the held word is known not to be last once another char follows
               if (hold_valid_ff) begin
                  push      = 1'b1;
                  push_char = hold_char_ff;
                  push_cv   = 1'b1;
               end
               hold_valid_in = 1'b1;
               hold_char_in  = byte_rdata;
               pos_in        = pos_ff + TS_AW'(1);
               run_in        = run_ff + RUN_W'(1);
            end
         end
         S_FLUSH: begin
            if (hold_valid_ff) begin
               if (out_free) begin
                  push          = 1'b1;
                  push_char     = hold_char_ff;
                  push_cv       = 1'b1;
                  push_last     = !ends_ff;
                  push_cut      = cut_ff && !ends_ff;
                  hold_valid_in = 1'b0;
                  state_in      = ends_ff ? S_MARK : S_IDLE;
               end
            end else if (ends_ff) begin
               state_in = S_MARK;
            end else if (cut_ff) begin
               // cut token with no character still reports the cut
               if (out_free) begin
                  push      = 1'b1;
                  push_last = 1'b1;
                  push_cut  = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               push_end  = 1'b1;
               push_cut  = cut_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_cv_in    = out_cv_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      out_cut_in   = out_cut_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_char_in  = push_char;
         out_cv_in    = push_cv;
         out_last_in  = push_last;
         out_end_in   = push_end;
         out_cut_in   = push_cut;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         codes_left_ff    <= 8'd0;
         first_dropped_ff <= 1'b0;
         hold_valid_ff    <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         codes_left_ff    <= codes_left_in;
         first_dropped_ff <= first_dropped_in;
         hold_valid_ff    <= hold_valid_in;
         out_valid_ff     <= out_valid_in;
      end
      ends_ff      <= ends_in;
      cut_ff       <= cut_in;
      hold_char_ff <= hold_char_in;
      pos_ff       <= pos_in;
      run_ff       <= run_in;
      out_char_ff  <= out_char_in;
      out_cv_ff    <= out_cv_in;
      out_last_ff  <= out_last_in;
      out_end_ff   <= out_end_in;
      out_cut_ff   <= out_cut_in;
   end

   // byte read follows the next walk position so data lines up with pos_ff
   assign rd.byte_raddr  = pos_in;
   assign rd.start_raddr = name_byte;
   assign idle           = (state_ff == S_IDLE);

   assign rsp_valid       = out_valid_ff;
   assign rsp_symbol_char = out_char_ff;
   assign rsp_char_valid  = out_cv_ff;
   assign rsp_run_last    = out_last_ff;
   assign rsp_symbol_end  = out_end_ff;
   assign rsp_token_cut   = out_cut_ff;

endmodule

// ----- hw/rtl/tdne_checker.sv -----
// port-level checks for the token dictionary name expander
module tdne_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_symbol_char,
   input logic        rsp_char_valid,
   input logic        rsp_run_last,
   input logic        rsp_symbol_end,
   input logic        rsp_token_cut
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol_char)
         && $stable(rsp_run_last) && $stable(rsp_symbol_end))
      else $error("stalled rsp word changed");

   // end marker closes the item and carries no character
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_symbol_end |-> rsp_run_last && !rsp_char_valid)
      else $error("end marker malformed");

   a_nochar_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_symbol_char == 8'd0)
      else $error("non-character word has nonzero char");

   a_cut_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_cut |-> rsp_run_last)
      else $error("cut flag off the last word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not quiet after reset");

endmodule

bind token_dictionary_name_expander tdne_checker u_tdne_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_symbol_char (rsp_symbol_char),
   .rsp_char_valid  (rsp_char_valid),
   .rsp_run_last    (rsp_run_last),
   .rsp_symbol_end  (rsp_symbol_end),
   .rsp_token_cut   (rsp_token_cut)
);

// ----- tb/token_dictionary_name_expander_test.sv -----
// self-checking testbench for the token dictionary name expander
`timescale 1ns / 1ps

module token_dictionary_name_expander_test
   import tdne_pkg::*;
();

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 160;
   localparam int LONG_NAME_CODES = 40;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 64;

   typedef struct packed {
      logic [7:0] symbol_char;
      logic       char_valid;
      logic       run_last;
      logic       symbol_end;
      logic       token_cut;
   } char_word_type;

   typedef struct packed {
      logic [1:0]    mode;
      logic [11:0]   where;
      logic [11:0]   value;
      logic          fixed;
      logic          fixed_has;
      char_word_type word;
   } stim_row_type;

   localparam char_word_type NO_WORD  = '0;
   localparam char_word_type END_ONLY = '{symbol_char: 8'h00, char_valid: 1'b0,
                                          run_last: 1'b1, symbol_end: 1'b1,
                                          token_cut: 1'b0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_UNUSED;
   logic [11:0] req_where = '0;
   logic [11:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_symbol_char;
   logic        rsp_char_valid;
   logic        rsp_run_last;
   logic        rsp_symbol_end;
   logic        rsp_token_cut;

   token_dictionary_name_expander DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_mode, .req_where, .req_value,
      .rsp_valid, .rsp_ready, .rsp_symbol_char, .rsp_char_valid,
      .rsp_run_last, .rsp_symbol_end, .rsp_token_cut
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // dictionary copy and name state
   logic [7:0]       dict_bytes   [TOKEN_STORE_BYTES];
   bit               byte_loaded  [TOKEN_STORE_BYTES];
   logic [TS_AW-1:0] dict_starts  [IDX_DEPTH];
   bit               start_loaded [IDX_DEPTH];
   logic [7:0]       codes_pending = 8'h00;
   bit               lead_dropped  = 1'b0;

   char_word_type pending_chars[$];
   char_word_type fresh_chars[$];

   int  error_count = 0;
   int  words_sent = 0;
   int  opening_words = 0;
   int  results_seen = 0;
   int  names_closed = 0;
   int  cuts_seen = 0;
   int  gap_before_next = 1;
   bit  steady_send = 1'b0;
   bit  steady_recv = 1'b0;
   logic [TS_AW-1:0] dict_cursor = '0;

   stim_row_type opening_rows [0:21] = '{
      '{MODE_NAME,       12'h000, 12'h000, 1'b1, 1'b1, END_ONLY},
      '{MODE_UNUSED,     12'hFFF, 12'hFFF, 1'b1, 1'b0, NO_WORD},
      '{MODE_TOKEN_BYTE, 12'hFFE, 12'hF61, 1'b1, 1'b0, NO_WORD},
      '{MODE_TOKEN_BYTE, 12'hFFF, 12'h062, 1'b1, 1'b0, NO_WORD},
      '{MODE_TOKEN_BYTE, 12'h000, 12'h0FF, 1'b1, 1'b0, NO_WORD},
      '{MODE_TOKEN_BYTE, 12'h001, 12'h000, 1'b1, 1'b0, NO_WORD},
      '{MODE_TOKEN_BYTE, 12'h002, 12'h07A, 1'b1, 1'b0, NO_WORD},
      '{MODE_TOKEN_BYTE, 12'h003, 12'h000, 1'b1, 1'b0, NO_WORD},
      '{MODE_INDEX,      12'hF00, 12'hFFE, 1'b1, 1'b0, NO_WORD},
      '{MODE_INDEX,      12'hFFF, 12'h002, 1'b1, 1'b0, NO_WORD},
      '{MODE_INDEX,      12'h101, 12'h001, 1'b1, 1'b0, NO_WORD},
      '{MODE_NAME,       12'hABC, 12'h001, 1'b1, 1'b0, NO_WORD},
      '{MODE_NAME,       12'h000, 12'h000, 1'b0, 1'b0, NO_WORD},
      '{MODE_NAME,       12'h555, 12'hF03, 1'b1, 1'b0, NO_WORD},
      '{MODE_NAME,       12'h000, 12'h001, 1'b0, 1'b0, NO_WORD},
      '{MODE_NAME,       12'h000, 12'h0FF, 1'b0, 1'b0, NO_WORD},
      '{MODE_NAME,       12'h000, 12'h300, 1'b0, 1'b0, NO_WORD},
      '{MODE_NAME,       12'h000, 12'h100, 1'b1, 1'b1, END_ONLY},
      '{MODE_NAME,       12'h000, 12'h002, 1'b1, 1'b0, NO_WORD},
      '{MODE_NAME,       12'h000, 12'h0FF, 1'b0, 1'b0, NO_WORD},
      '{MODE_TOKEN_BYTE, 12'h002, 12'h079, 1'b1, 1'b0, NO_WORD},
      '{MODE_NAME,       12'h000, 12'hFFF, 1'b0, 1'b0, NO_WORD}
   };

   function automatic int pick_gap(input bit steady);
      return steady ? 0 : int'($urandom_range(0, 7));
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      $display("ERROR %0t: %s", $time, msg);
   endtask

   // works out the characters one accepted word gives, into fresh_chars
   function automatic void expand_name_byte(input logic [1:0] mode, input logic [11:0] where,
                                            input logic [11:0] value);
      logic [TS_AW-1:0] pos;
      int               steps;
      bit               cut;
      char_word_type    w;
      fresh_chars.delete();
      case (mode)
         MODE_TOKEN_BYTE: begin
            dict_bytes[where[TS_AW-1:0]] = value[7:0];
            byte_loaded[where[TS_AW-1:0]] = 1'b1;
         end
         MODE_INDEX: begin
            dict_starts[where[7:0]] = value[TS_AW-1:0];
            start_loaded[where[7:0]] = 1'b1;
         end
         MODE_NAME: begin
            if (codes_pending == 8'h00) begin
               codes_pending = value[7:0];
               lead_dropped = 1'b0;
               if (codes_pending == 8'h00)
                  fresh_chars.push_back(END_ONLY);
            end else begin
               pos = dict_starts[value[7:0]];
               steps = 0;
               while (steps < RUN_CAP && dict_bytes[pos] != 8'h00) begin
                  if (lead_dropped) begin
                     w = '0;
                     w.symbol_char = dict_bytes[pos];
                     w.char_valid = 1'b1;
                     fresh_chars.push_back(w);
                  end else begin
                     lead_dropped = 1'b1;
                  end
                  pos = pos + 1'b1;
                  steps++;
               end
               cut = (steps == RUN_CAP) && (dict_bytes[pos] != 8'h00);
               codes_pending = codes_pending - 1'b1;
               if (codes_pending == 8'h00) begin
                  w = '0;
                  w.symbol_end = 1'b1;
                  fresh_chars.push_back(w);
               end else if (cut && fresh_chars.size() == 0) begin
                  fresh_chars.push_back(NO_WORD);
               end
               if (fresh_chars.size() > 0) begin
                  w = fresh_chars.pop_back();
                  w.run_last = 1'b1;
                  w.token_cut = cut;
                  fresh_chars.push_back(w);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // a slot whose whole walk, including the byte after a full run, is loaded
   function automatic int pick_safe_slot();
      int               usable[$];
      logic [TS_AW-1:0] pos;
      bit               ok;
      for (int s = 0; s < IDX_DEPTH; s++) begin
         if (!start_loaded[s])
            continue;
         pos = dict_starts[s];
         ok = 1'b0;
         for (int k = 0; k <= RUN_CAP; k++) begin
            if (!byte_loaded[pos])
               break;
            if (dict_bytes[pos] == 8'h00 || k == RUN_CAP) begin
               ok = 1'b1;
               break;
            end
            pos = pos + 1'b1;
         end
         if (ok)
            usable.push_back(s);
      end
      if (usable.size() == 0)
         return -1;
      return usable[$urandom_range(0, usable.size() - 1)];
   endfunction

   task automatic send_word(input logic [1:0] mode, input logic [11:0] where,
                            input logic [11:0] value, input bit fixed = 1'b0,
                            input bit fixed_has = 1'b0,
                            input char_word_type fixed_word = '0);
      repeat (gap_before_next) @(posedge clock);
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_where <= where;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expand_name_byte(mode, where, value);
      if (fixed) begin
         fresh_chars.delete();
         if (fixed_has)
            fresh_chars.push_back(fixed_word);
      end
      foreach (fresh_chars[k])
         pending_chars.push_back(fresh_chars[k]);
      if (mode != MODE_UNUSED)
         words_sent++;
      // valid only drops here when the next word is not sent back to back
      gap_before_next = pick_gap(steady_send);
      if (gap_before_next > 0)
         req_valid <= 1'b0;
   endtask

   // must be called in the step of the last acceptance
   task automatic drain_wait();
      if (gap_before_next == 0) begin
         req_valid <= 1'b0;
         gap_before_next = 1;
      end
      while (pending_chars.size() > 0) @(posedge clock);
   endtask

   task automatic lay_token();
      logic [TS_AW-1:0] first;
      int               len;
      int               pick;
      int               offset;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         len = 0;
      else if (pick < 75)
         len = $urandom_range(1, 6);
      else if (pick < 85)
         len = $urandom_range(29, 31);
      else
         len = $urandom_range(32, 40);
      first = dict_cursor;
      repeat (len) begin
         send_word(MODE_TOKEN_BYTE, dict_cursor, {4'($urandom), 8'($urandom_range(1, 255))});
         dict_cursor = dict_cursor + 1'b1;
      end
      send_word(MODE_TOKEN_BYTE, dict_cursor, {4'($urandom), 8'h00});
      dict_cursor = dict_cursor + 1'b1;
      repeat ($urandom_range(1, 2)) begin
         offset = 0;
         if (len > 1 && $urandom_range(0, 3) == 0)
            offset = $urandom_range(1, len - 1);
         send_word(MODE_INDEX, {4'($urandom), 8'($urandom)}, 12'(first + offset));
      end
   endtask

   task automatic send_name(input int code_count);
      int slot;
      send_word(MODE_NAME, 12'($urandom), {4'($urandom), 8'(code_count)});
      repeat (code_count) begin
         // stray words in the middle of a name
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: send_word(MODE_UNUSED, 12'($urandom), 12'($urandom));
               1: send_word(MODE_TOKEN_BYTE, 12'($urandom), 12'($urandom));
               default: send_word(MODE_INDEX, 12'($urandom), 12'($urandom));
            endcase
         end
         slot = pick_safe_slot();
         if (slot < 0) begin
            lay_token();
            slot = pick_safe_slot();
         end
         send_word(MODE_NAME, 12'($urandom), {4'($urandom), 8'(slot)});
      end
   endtask

   // result side
   initial begin
      int            stall;
      char_word_type got;
      char_word_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap(steady_recv);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got = {rsp_symbol_char, rsp_char_valid, rsp_run_last, rsp_symbol_end, rsp_token_cut};
         results_seen++;
         if (got.symbol_end === 1'b1)
            names_closed++;
         if (got.token_cut === 1'b1)
            cuts_seen++;
         if (pending_chars.size() == 0) begin
            flag_error($sformatf("word %0d arrived with nothing expected: %h",
                                 results_seen, got));
         end else begin
            want = pending_chars.pop_front();
            if (got.symbol_char !== want.symbol_char)
               flag_error($sformatf("word %0d symbol_char %h, want %h",
                                    results_seen, got.symbol_char, want.symbol_char));
            if (got.char_valid !== want.char_valid)
               flag_error($sformatf("word %0d char_valid %b, want %b",
                                    results_seen, got.char_valid, want.char_valid));
            if (got.run_last !== want.run_last)
               flag_error($sformatf("word %0d run_last %b, want %b",
                                    results_seen, got.run_last, want.run_last));
            if (got.symbol_end !== want.symbol_end)
               flag_error($sformatf("word %0d symbol_end %b, want %b",
                                    results_seen, got.symbol_end, want.symbol_end));
            if (got.token_cut !== want.token_cut)
               flag_error($sformatf("word %0d token_cut %b, want %b",
                                    results_seen, got.token_cut, want.token_cut));
         end
      end
   end

   // watchdog: cycles in a row with no word moving on either side
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no word moved for %0d cycles, %0d still expected",
               STALL_LIMIT, pending_chars.size());
      $display("token_dictionary_name_expander_test: done, errors");
      $finish;
   end

   initial begin
      int pick;
      int random_goal;
      bit long_name_done;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         send_word(opening_rows[i].mode, opening_rows[i].where, opening_rows[i].value,
                   opening_rows[i].fixed, opening_rows[i].fixed_has, opening_rows[i].word);
      opening_words = words_sent;
      drain_wait();

      dict_cursor = 12'($urandom_range(3900, 4095));
      random_goal = words_sent + RANDOM_WORDS;
      long_name_done = 1'b0;
      while (words_sent < random_goal) begin
         steady_send = ($urandom_range(0, 3) == 0);
         steady_recv = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 2)) lay_token();
         // one long name
         if (!long_name_done && words_sent > opening_words + 60) begin
            send_name(LONG_NAME_CODES);
            long_name_done = 1'b1;
         end
         repeat ($urandom_range(2, 5)) begin
            pick = $urandom_range(0, 9);
            send_name(pick == 0 ? 0 : int'($urandom_range(1, 5)));
         end
         if ($urandom_range(0, 2) == 0)
            drain_wait();
      end

      drain_wait();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d input words (%0d from the opening table), %0d result words",
               words_sent, opening_words, results_seen);
      $display("%0d names closed, %0d cut tokens, %0d mismatches",
               names_closed, cuts_seen, error_count);
      if (error_count == 0)
         $display("token_dictionary_name_expander_test: done, clean");
      else
         $display("token_dictionary_name_expander_test: done, errors");
      $finish;
   end

endmodule
